/* rtl/core/gdo_pkg.sv */
package gdo_pkg;

  localparam int YEAR_W      = 14;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int OFFSET_BITS = 23;
  localparam int MAX_YEAR    = 9999;
  localparam int MONTHS      = 12;

  // days from 0000-01-01 to the start of any 14-bit year fit here
  localparam int YS_W  = 23;
  localparam int DN_W  = ((OFFSET_BITS > YS_W) ? OFFSET_BITS : YS_W) + 2;
  localparam int CUM_W = 9;
  localparam int BIT_W = $clog2(YEAR_W);

  // x / 100 as (x * 5243) >> 19, exact for any 14-bit x
  localparam int DIV100_MUL = 5243;
  localparam int DIV100_SH  = 19;
  localparam int PROD_W     = YEAR_W + 13;

  localparam logic [DAY_W-1:0] MONTH_LEN [0:12] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [CUM_W-1:0] CUM_DAYS [0:12] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_BAD_DATE = 2'd1,
    STS_RANGE    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_YS_A,
    ST_SUM_A,
    ST_YS_B,
    ST_DIFF,
    ST_SHIFT,
    ST_RANGE,
    ST_SEARCH,
    ST_REM,
    ST_MONTH,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CHECK,
    OP_YS_A,
    OP_SUM_A,
    OP_YS_B,
    OP_DIFF,
    OP_SHIFT,
    OP_RANGE,
    OP_SEARCH,
    OP_REM,
    OP_MONTH,
    OP_EMIT,
    OP_WAIT
  } dp_op_t;

  typedef struct packed {
    logic accepted;
    logic is_diff;
    logic bad_date;
    logic out_of_range;
    logic search_last;
    logic month_done;
    logic out_free;
  } dp_sts_t;

  function automatic logic [YEAR_W-1:0] div100_f(input logic [YEAR_W-1:0] x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(DIV100_MUL);
    return YEAR_W'(prod >> DIV100_SH);
  endfunction

  function automatic logic leap_f(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] q;
    logic [YEAR_W-1:0] r;
    q = div100_f(y);
    r = y - q * YEAR_W'(100);
    return ((y[1:0] == 2'b00) && (r != '0)) || ((r == '0) && (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] month_len_f(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DAY_W-1:0] d;
    d = '0;
    if ((m >= MONTH_W'(1)) && (m <= MONTH_W'(MONTHS))) begin
      d = MONTH_LEN[m];
      if ((m == MONTH_W'(2)) && leap) begin
        d = DAY_W'(29);
      end
    end
    return d;
  endfunction

  function automatic logic date_valid_f(input logic [YEAR_W-1:0] y,
                                        input logic [MONTH_W-1:0] m,
                                        input logic [DAY_W-1:0] d);
    return (y <= YEAR_W'(MAX_YEAR)) && (m >= MONTH_W'(1)) && (m <= MONTH_W'(MONTHS)) &&
           (d >= DAY_W'(1)) && (d <= month_len_f(m, leap_f(y)));
  endfunction

  // days from 0000-01-01 to january 1st of year y
  function automatic logic [YS_W-1:0] year_start_f(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] p;
    logic [YEAR_W-1:0] q4;
    logic [YEAR_W-1:0] q100;
    logic [YEAR_W-1:0] q400;
    logic [YS_W-1:0]   s;
    p    = y - YEAR_W'(1);
    q4   = p >> 2;
    q100 = div100_f(p);
    q400 = div100_f(q4);
    s    = YS_W'(y) * YS_W'(365) + YS_W'(q4) - YS_W'(q100) + YS_W'(q400) + YS_W'(1);
    if (y == '0) begin
      s = '0;
    end
    return s;
  endfunction

  function automatic logic [CUM_W-1:0] cum_days_f(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [CUM_W-1:0] c;
    c = '0;
    if (m <= MONTH_W'(MONTHS)) begin
      c = CUM_DAYS[m] + CUM_W'((leap && (m > MONTH_W'(2))) ? 1 : 0);
    end
    return c;
  endfunction

  function automatic logic [DN_W-1:0] day_num_f(input logic [YS_W-1:0] ys,
                                                 input logic [MONTH_W-1:0] m,
                                                 input logic [DAY_W-1:0] d,
                                                 input logic leap);
    return DN_W'(ys) + DN_W'(cum_days_f(m, leap)) + DN_W'(d) - DN_W'(1);
  endfunction

  localparam logic [DN_W-1:0] MAX_DAY_NUM =
    DN_W'(year_start_f(YEAR_W'(MAX_YEAR))) +
    (leap_f(YEAR_W'(MAX_YEAR)) ? DN_W'(365) : DN_W'(364));

  localparam logic signed [DN_W-1:0] CNT_MAX = DN_W'((1 << (OFFSET_BITS - 1)) - 1);
  localparam logic signed [DN_W-1:0] CNT_MIN = DN_W'(-(1 << (OFFSET_BITS - 1)));

endpackage

/* rtl/core/gdo_if.sv */
interface gdo_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic [gdo_pkg::YEAR_W-1:0]           year;
  logic [gdo_pkg::MONTH_W-1:0]          month;
  logic [gdo_pkg::DAY_W-1:0]            day;
  logic signed [gdo_pkg::OFFSET_BITS-1:0] offset;
  logic [gdo_pkg::YEAR_W-1:0]           other_year;
  logic [gdo_pkg::MONTH_W-1:0]          other_month;
  logic [gdo_pkg::DAY_W-1:0]            other_day;

  modport source (
    output valid, cmd, year, month, day, offset, other_year, other_month, other_day,
    input  ready
  );

  modport sink (
    input  valid, cmd, year, month, day, offset, other_year, other_month, other_day,
    output ready
  );
endinterface

interface gdo_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [gdo_pkg::YEAR_W-1:0]             result_year;
  logic [gdo_pkg::MONTH_W-1:0]            result_month;
  logic [gdo_pkg::DAY_W-1:0]              result_day;
  logic signed [gdo_pkg::OFFSET_BITS-1:0] day_count;
  logic [1:0]                             status;

  modport source (
    output valid, result_year, result_month, result_day, day_count, status,
    input  ready
  );

  modport sink (
    input  valid, result_year, result_month, result_day, day_count, status,
    output ready
  );
endinterface

/* rtl/core/gdo_ctrl.sv */
module gdo_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  gdo_pkg::dp_sts_t sts,
  output gdo_pkg::dp_op_t  op
);

  gdo_pkg::ctl_state_t state_r;
  gdo_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gdo_pkg::ST_IDLE: begin
        if (sts.accepted) state_nxt = gdo_pkg::ST_CHECK;
      end
      gdo_pkg::ST_CHECK: begin
        state_nxt = sts.bad_date ? gdo_pkg::ST_DONE : gdo_pkg::ST_YS_A;
      end
      gdo_pkg::ST_YS_A:  state_nxt = gdo_pkg::ST_SUM_A;
      gdo_pkg::ST_SUM_A: begin
        state_nxt = sts.is_diff ? gdo_pkg::ST_YS_B : gdo_pkg::ST_SHIFT;
      end
      gdo_pkg::ST_YS_B:  state_nxt = gdo_pkg::ST_DIFF;
      gdo_pkg::ST_DIFF:  state_nxt = gdo_pkg::ST_DONE;
      gdo_pkg::ST_SHIFT: state_nxt = gdo_pkg::ST_RANGE;
      gdo_pkg::ST_RANGE: begin
        state_nxt = sts.out_of_range ? gdo_pkg::ST_DONE : gdo_pkg::ST_SEARCH;
      end
      gdo_pkg::ST_SEARCH: begin
        if (sts.search_last) state_nxt = gdo_pkg::ST_REM;
      end
      gdo_pkg::ST_REM: state_nxt = gdo_pkg::ST_MONTH;
      gdo_pkg::ST_MONTH: begin
        if (sts.month_done) state_nxt = gdo_pkg::ST_DONE;
      end
      gdo_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = gdo_pkg::ST_IDLE;
      end
      default: state_nxt = gdo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op = gdo_pkg::OP_WAIT;
    unique case (state_r)
      gdo_pkg::ST_IDLE:   op = gdo_pkg::OP_IDLE;
      gdo_pkg::ST_CHECK:  op = gdo_pkg::OP_CHECK;
      gdo_pkg::ST_YS_A:   op = gdo_pkg::OP_YS_A;
      gdo_pkg::ST_SUM_A:  op = gdo_pkg::OP_SUM_A;
      gdo_pkg::ST_YS_B:   op = gdo_pkg::OP_YS_B;
      gdo_pkg::ST_DIFF:   op = gdo_pkg::OP_DIFF;
      gdo_pkg::ST_SHIFT:  op = gdo_pkg::OP_SHIFT;
      gdo_pkg::ST_RANGE:  op = gdo_pkg::OP_RANGE;
      gdo_pkg::ST_SEARCH: op = gdo_pkg::OP_SEARCH;
      gdo_pkg::ST_REM:    op = gdo_pkg::OP_REM;
      gdo_pkg::ST_MONTH:  op = gdo_pkg::OP_MONTH;
      gdo_pkg::ST_DONE:   op = sts.out_free ? gdo_pkg::OP_EMIT : gdo_pkg::OP_WAIT;
      default:            op = gdo_pkg::OP_WAIT;
    endcase
  end

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdo_pkg::ST_IDLE) && sts.accepted |=> (state_r == gdo_pkg::ST_CHECK))
    else $error("accepted item did not start checking");

  a_range_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdo_pkg::ST_RANGE) && sts.out_of_range |=> (state_r == gdo_pkg::ST_DONE))
    else $error("out of range date went on to the year search");

  a_month_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdo_pkg::ST_MONTH) && sts.month_done |=> (state_r == gdo_pkg::ST_DONE))
    else $error("month walk did not finish");

endmodule

/* rtl/core/gdo_dp.sv */
module gdo_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  gdo_pkg::dp_op_t  op,
  output gdo_pkg::dp_sts_t sts,
  gdo_in_if.sink           in_ch,
  gdo_out_if.source        out_ch
);

  logic                                   cmd_r;
  logic [gdo_pkg::YEAR_W-1:0]             y_r;
  logic [gdo_pkg::MONTH_W-1:0]            m_r;
  logic [gdo_pkg::DAY_W-1:0]              d_r;
  logic signed [gdo_pkg::OFFSET_BITS-1:0] off_r;
  logic [gdo_pkg::YEAR_W-1:0]             oy_r;
  logic [gdo_pkg::MONTH_W-1:0]            om_r;
  logic [gdo_pkg::DAY_W-1:0]              od_r;

  gdo_pkg::status_t                       status_r;
  logic [gdo_pkg::YS_W-1:0]               ys_r;
  logic                                   leap_r;
  logic signed [gdo_pkg::DN_W-1:0]        a_r;
  logic signed [gdo_pkg::OFFSET_BITS-1:0] cnt_r;
  logic [gdo_pkg::YEAR_W-1:0]             yy_r;
  logic [gdo_pkg::MONTH_W-1:0]            mm_r;
  logic [gdo_pkg::BIT_W-1:0]              bit_r;

  logic                                   out_valid_r;
  logic [gdo_pkg::YEAR_W-1:0]             out_year_r;
  logic [gdo_pkg::MONTH_W-1:0]            out_month_r;
  logic [gdo_pkg::DAY_W-1:0]              out_day_r;
  logic signed [gdo_pkg::OFFSET_BITS-1:0] out_cnt_r;
  gdo_pkg::status_t                       out_status_r;

  logic                                   accept;
  logic [gdo_pkg::YEAR_W-1:0]             cand;
  logic [gdo_pkg::YS_W-1:0]               cand_start;
  logic signed [gdo_pkg::DN_W-1:0]        b_num;
  logic signed [gdo_pkg::DN_W-1:0]        diff;
  logic [gdo_pkg::DAY_W-1:0]              dim_cur;

  assign in_ch.ready = rst_n && (op == gdo_pkg::OP_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // bit-by-bit search for the last year starting on or before a_r
  assign cand       = yy_r | (gdo_pkg::YEAR_W'(1) << bit_r);
  assign cand_start = gdo_pkg::year_start_f(cand);

  assign b_num   = $signed(gdo_pkg::day_num_f(ys_r, om_r, od_r, leap_r));
  assign diff    = a_r - b_num;
  assign dim_cur = gdo_pkg::month_len_f(mm_r, leap_r);

  always_comb begin
    sts.accepted     = accept;
    sts.is_diff      = cmd_r;
    sts.bad_date     = !gdo_pkg::date_valid_f(y_r, m_r, d_r) ||
                       (cmd_r && !gdo_pkg::date_valid_f(oy_r, om_r, od_r));
    sts.out_of_range = (a_r < 0) || (a_r > $signed(gdo_pkg::MAX_DAY_NUM));
    sts.search_last  = (bit_r == '0);
    sts.month_done   = (mm_r >= gdo_pkg::MONTH_W'(gdo_pkg::MONTHS)) ||
                       (a_r < $signed(gdo_pkg::DN_W'(dim_cur)));
    sts.out_free     = !out_valid_r || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    unique case (op)
      gdo_pkg::OP_IDLE: begin
        if (accept) begin
          cmd_r    <= in_ch.cmd;
          y_r      <= in_ch.year;
          m_r      <= in_ch.month;
          d_r      <= in_ch.day;
          off_r    <= in_ch.offset;
          oy_r     <= in_ch.other_year;
          om_r     <= in_ch.other_month;
          od_r     <= in_ch.other_day;
          status_r <= gdo_pkg::STS_OK;
          cnt_r    <= '0;
          yy_r     <= '0;
          mm_r     <= gdo_pkg::MONTH_W'(1);
          bit_r    <= gdo_pkg::BIT_W'(gdo_pkg::YEAR_W - 1);
        end
      end
      gdo_pkg::OP_CHECK: begin
        if (sts.bad_date) status_r <= gdo_pkg::STS_BAD_DATE;
      end
      gdo_pkg::OP_YS_A: begin
        ys_r   <= gdo_pkg::year_start_f(y_r);
        leap_r <= gdo_pkg::leap_f(y_r);
      end
      gdo_pkg::OP_SUM_A: begin
        a_r <= $signed(gdo_pkg::day_num_f(ys_r, m_r, d_r, leap_r));
      end
      gdo_pkg::OP_YS_B: begin
        ys_r   <= gdo_pkg::year_start_f(oy_r);
        leap_r <= gdo_pkg::leap_f(oy_r);
      end
      gdo_pkg::OP_DIFF: begin
        if ((diff > gdo_pkg::CNT_MAX) || (diff < gdo_pkg::CNT_MIN)) begin
          status_r <= gdo_pkg::STS_RANGE;
        end else begin
          cnt_r <= diff[gdo_pkg::OFFSET_BITS-1:0];
        end
      end
      gdo_pkg::OP_SHIFT: begin
        a_r <= a_r + gdo_pkg::DN_W'(off_r);
      end
      gdo_pkg::OP_RANGE: begin
        if (sts.out_of_range) status_r <= gdo_pkg::STS_RANGE;
      end
      gdo_pkg::OP_SEARCH: begin
        if ($signed(gdo_pkg::DN_W'(cand_start)) <= a_r) yy_r <= cand;
        bit_r <= bit_r - gdo_pkg::BIT_W'(1);
      end
      gdo_pkg::OP_REM: begin
        a_r    <= a_r - $signed(gdo_pkg::DN_W'(gdo_pkg::year_start_f(yy_r)));
        leap_r <= gdo_pkg::leap_f(yy_r);
      end
      gdo_pkg::OP_MONTH: begin
        if (!sts.month_done) begin
          a_r  <= a_r - $signed(gdo_pkg::DN_W'(dim_cur));
          mm_r <= mm_r + gdo_pkg::MONTH_W'(1);
        end
      end
      gdo_pkg::OP_EMIT: begin
        out_status_r <= status_r;
        if ((status_r == gdo_pkg::STS_OK) && cmd_r) begin
          out_cnt_r <= cnt_r;
        end else begin
          out_cnt_r <= '0;
        end
        if ((status_r == gdo_pkg::STS_OK) && !cmd_r) begin
          out_year_r  <= yy_r;
          out_month_r <= mm_r;
          out_day_r   <= a_r[gdo_pkg::DAY_W-1:0] + gdo_pkg::DAY_W'(1);
        end else begin
          out_year_r  <= '0;
          out_month_r <= '0;
          out_day_r   <= '0;
        end
      end
      gdo_pkg::OP_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == gdo_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_year  = out_year_r;
  assign out_ch.result_month = out_month_r;
  assign out_ch.result_day   = out_day_r;
  assign out_ch.day_count    = out_cnt_r;
  assign out_ch.status       = out_status_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != gdo_pkg::STS_OK) |->
      (out_year_r == '0) && (out_month_r == '0) && (out_day_r == '0) && (out_cnt_r == '0))
    else $error("error result carries nonzero fields");

  a_date_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == gdo_pkg::STS_OK) && (out_month_r != '0) |->
      (out_day_r != '0) && (out_month_r <= gdo_pkg::MONTH_W'(gdo_pkg::MONTHS)) &&
      (out_cnt_r == '0))
    else $error("shifted date malformed");

  a_search_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (op == gdo_pkg::OP_SEARCH) |-> (a_r >= 0) && (status_r == gdo_pkg::STS_OK))
    else $error("year search on a rejected day number");

endmodule

/* rtl/core/gregorian_date_offset_and_difference_unit.sv */
// channel  dir  handshake        payload
// in_ch    in   valid / ready    cmd, year, month, day, offset, other date
// out_ch   out  valid / ready    result date, day_count, status
//
// difference: check, year start, sum, other year start, diff, out register
// add: after the shift and range check, a 14-step year search through the
// year start unit and a walk of up to 11 months lead to the output register
// a bad input date goes from the check state straight to the done state
// the next item is taken once the result is in the output register
// rst_n is synchronous; a stalled result holds the unit in its last state
module gregorian_date_offset_and_difference_unit (
  input  logic      clk,
  input  logic      rst_n,
  gdo_in_if.sink    in_ch,
  gdo_out_if.source out_ch
);

  gdo_pkg::dp_op_t  op;
  gdo_pkg::dp_sts_t sts;

  gdo_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .op    (op)
  );

  gdo_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (op),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

/* tb/tb_gregorian_date_offset_and_difference_unit.sv */
`timescale 1ns / 1ps

module tb_gregorian_date_offset_and_difference_unit;
  import gdo_pkg::*;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_DIFF = 1'b1
  } date_cmd_t;

  typedef struct {
    date_cmd_t                cmd;
    logic [YEAR_W-1:0]        year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
    logic signed [OFFSET_BITS-1:0] offset;
    logic [YEAR_W-1:0]        other_year;
    logic [MONTH_W-1:0]       other_month;
    logic [DAY_W-1:0]         other_day;
  } date_item_t;

  typedef struct {
    logic [YEAR_W-1:0]             year;
    logic [MONTH_W-1:0]            month;
    logic [DAY_W-1:0]              day;
    logic signed [OFFSET_BITS-1:0] count;
    status_t                       status;
  } answer_t;

  localparam int DAYS_IN [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam longint COUNT_TOP = (longint'(1) << (OFFSET_BITS - 1)) - 1;

  logic clk = 1'b0;
  logic rst_n;

  gdo_in_if  in_ch ();
  gdo_out_if out_ch ();

  gregorian_date_offset_and_difference_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  answer_t pending_answers [$];
  answer_t want;
  bit      send_idle;
  bit      recv_idle;
  int      hold_len;
  int      errors;
  int      n_add;
  int      n_diff;
  int      n_ok;
  int      n_bad;
  int      n_range;

  // calendar arithmetic

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int y, int m);
    if (m < 1 || m > MONTHS) begin
      return 0;
    end
    if (m == 2 && leap_year(y)) begin
      return 29;
    end
    return DAYS_IN[m];
  endfunction

  function automatic int jan1_days(int y);
    int p;
    if (y <= 0) begin
      return 0;
    end
    p = y - 1;
    return 365 * y + p / 4 - p / 100 + p / 400 + 1;
  endfunction

  function automatic bit valid_date(int y, int m, int d);
    return (y <= MAX_YEAR) && (m >= 1) && (m <= MONTHS) && (d >= 1) &&
           (d <= month_days(y, m));
  endfunction

  function automatic int day_index(int y, int m, int d);
    int n;
    n = jan1_days(y);
    for (int k = 1; k < m && k <= MONTHS; k++) begin
      n += month_days(y, k);
    end
    return n + d - 1;
  endfunction

  function automatic void split_day_index(input int n, output int y, output int m,
                                          output int d);
    int rest;
    y = int'((longint'(n) * 400) / 146097);
    while (y > 0 && jan1_days(y) > n) begin
      y--;
    end
    while (jan1_days(y + 1) <= n) begin
      y++;
    end
    rest = n - jan1_days(y);
    m = 1;
    while (m < MONTHS && rest >= month_days(y, m)) begin
      rest -= month_days(y, m);
      m++;
    end
    d = rest + 1;
  endfunction

  function automatic answer_t compute_answer(date_item_t it);
    answer_t ans;
    longint  here;
    longint  moved;
    int      ry;
    int      rm;
    int      rd;
    ans.year   = '0;
    ans.month  = '0;
    ans.day    = '0;
    ans.count  = '0;
    ans.status = STS_OK;
    if (!valid_date(it.year, it.month, it.day)) begin
      ans.status = STS_BAD_DATE;
      return ans;
    end
    here = day_index(it.year, it.month, it.day);
    if (it.cmd == CMD_ADD) begin
      moved = here + longint'(it.offset);
      if (moved < 0 || moved > day_index(MAX_YEAR, MONTHS, 31)) begin
        ans.status = STS_RANGE;
      end else begin
        split_day_index(int'(moved), ry, rm, rd);
        ans.year  = YEAR_W'(ry);
        ans.month = MONTH_W'(rm);
        ans.day   = DAY_W'(rd);
      end
    end else if (!valid_date(it.other_year, it.other_month, it.other_day)) begin
      ans.status = STS_BAD_DATE;
    end else begin
      moved = here - day_index(it.other_year, it.other_month, it.other_day);
      if (moved > COUNT_TOP || moved < -COUNT_TOP - 1) begin
        ans.status = STS_RANGE;
      end else begin
        ans.count = OFFSET_BITS'(moved);
      end
    end
    return ans;
  endfunction

  // item construction

  function automatic date_item_t mk(date_cmd_t cmd, int y, int m, int d, int off,
                                    int oy, int om, int od);
    date_item_t it;
    it.cmd         = cmd;
    it.year        = YEAR_W'(y);
    it.month       = MONTH_W'(m);
    it.day         = DAY_W'(d);
    it.offset      = OFFSET_BITS'(off);
    it.other_year  = YEAR_W'(oy);
    it.other_month = MONTH_W'(om);
    it.other_day   = DAY_W'(od);
    return it;
  endfunction

  function automatic void pick_date(output int y, output int m, output int d);
    int notable [9] = '{0, 1, 4, 100, 400, 1900, 2000, 9998, MAX_YEAR};
    if ($urandom_range(0, 7) == 0) begin
      y = notable[$urandom_range(0, 8)];
    end else begin
      y = int'($urandom_range(0, MAX_YEAR));
    end
    m = int'($urandom_range(1, MONTHS));
    if ($urandom_range(0, 3) == 0) begin
      d = month_days(y, m);
    end else begin
      d = int'($urandom_range(1, month_days(y, m)));
    end
  endfunction

  function automatic date_item_t random_item();
    date_item_t it;
    int         y;
    int         m;
    int         d;
    int         oy;
    int         om;
    int         od;
    int         off;
    int         last_day;
    int         kind;
    last_day = day_index(MAX_YEAR, MONTHS, 31);
    pick_date(y, m, d);
    pick_date(oy, om, od);
    case ($urandom_range(0, 3))
      0: off = int'($urandom_range(0, 800)) - 400;
      1: off = int'($urandom_range(0, 80000)) - 40000;
      2: off = int'($urandom_range(0, 2 * last_day)) - last_day;
      default: off = int'($urandom);
    endcase
    it = mk(date_cmd_t'($urandom_range(0, 1)), y, m, d, off, oy, om, od);
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      it.year        = YEAR_W'($urandom);
      it.month       = MONTH_W'($urandom);
      it.day         = DAY_W'($urandom);
      it.other_year  = YEAR_W'($urandom);
      it.other_month = MONTH_W'($urandom);
      it.other_day   = DAY_W'($urandom);
    end else if (kind == 8) begin
      case ($urandom_range(0, 6))
        0: it.month = '0;
        1: it.month = MONTH_W'($urandom_range(MONTHS + 1, 15));
        2: it.day = '0;
        3: it.day = DAY_W'(month_days(y, m) + 1);
        4: it.year = YEAR_W'($urandom_range(MAX_YEAR + 1, (1 << YEAR_W) - 1));
        5: it.other_month = '0;
        default: it.other_day = DAY_W'(month_days(oy, om) + 1);
      endcase
    end
    return it;
  endfunction

  // channel handling

  task automatic send_item(input date_item_t it);
    int gap;
    gap = send_idle ? int'($urandom_range(0, 13)) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= it.cmd;
    in_ch.year        <= it.year;
    in_ch.month       <= it.month;
    in_ch.day         <= it.day;
    in_ch.offset      <= it.offset;
    in_ch.other_year  <= it.other_year;
    in_ch.other_month <= it.other_month;
    in_ch.other_day   <= it.other_day;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_answers.push_back(compute_answer(it));
    if (it.cmd == CMD_ADD) begin
      n_add++;
    end else begin
      n_diff++;
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = recv_idle ? int'($urandom_range(0, 13)) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready) && hold_len == 0) @(posedge clk);
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result arrived with nothing pending");
      end else begin
        want = pending_answers.pop_front();
        if (out_ch.result_year !== want.year) begin
          report_mismatch($sformatf("year got %0d want %0d", out_ch.result_year, want.year));
        end
        if (out_ch.result_month !== want.month) begin
          report_mismatch($sformatf("month got %0d want %0d",
                                    out_ch.result_month, want.month));
        end
        if (out_ch.result_day !== want.day) begin
          report_mismatch($sformatf("day got %0d want %0d", out_ch.result_day, want.day));
        end
        if (out_ch.day_count !== want.count) begin
          report_mismatch($sformatf("day_count got %0d want %0d",
                                    out_ch.day_count, want.count));
        end
        if (out_ch.status !== want.status) begin
          report_mismatch($sformatf("status got %0d want %0d", out_ch.status, want.status));
        end
        case (want.status)
          STS_OK:       n_ok++;
          STS_BAD_DATE: n_bad++;
          default:      n_range++;
        endcase
      end
    end
  end

  // tests

  task automatic test_directed_cases();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_item(mk(CMD_ADD, 0, 1, 1, 0, 0, 0, 0));
    send_item(mk(CMD_ADD, 0, 1, 1, -1, 0, 0, 0));
    send_item(mk(CMD_ADD, 9999, 12, 31, 1, 0, 0, 0));
    send_item(mk(CMD_ADD, 0, 1, 1, 4194303, 0, 0, 0));
    send_item(mk(CMD_ADD, 9999, 12, 31, -4194304, 0, 0, 0));
    send_item(mk(CMD_ADD, 9999, 12, 31, -3652424, 0, 0, 0));
    send_item(mk(CMD_ADD, 0, 1, 1, 3652424, 0, 0, 0));
    send_item(mk(CMD_ADD, 2000, 2, 28, 1, 0, 0, 0));
    send_item(mk(CMD_ADD, 1900, 2, 28, 1, 0, 0, 0));
    send_item(mk(CMD_ADD, 2024, 2, 29, 365, 16383, 15, 31));
    send_item(mk(CMD_ADD, 2020, 0, 10, 0, 0, 0, 0));
    send_item(mk(CMD_DIFF, 2020, 13, 1, 0, 2020, 1, 1));
    send_item(mk(CMD_ADD, 2020, 15, 31, 0, 0, 0, 0));
    send_item(mk(CMD_ADD, 2020, 5, 0, 0, 0, 0, 0));
    send_item(mk(CMD_ADD, 2021, 4, 31, 0, 0, 0, 0));
    send_item(mk(CMD_ADD, 1900, 2, 29, 0, 0, 0, 0));
    send_item(mk(CMD_DIFF, 2000, 2, 30, 0, 2000, 1, 1));
    send_item(mk(CMD_ADD, 10000, 1, 1, 0, 0, 0, 0));
    send_item(mk(CMD_ADD, 16383, 15, 31, -1, 0, 0, 0));
    send_item(mk(CMD_DIFF, 9999, 12, 31, 0, 0, 1, 1));
    send_item(mk(CMD_DIFF, 0, 1, 1, 0, 9999, 12, 31));
    send_item(mk(CMD_DIFF, 2024, 3, 1, 0, 2024, 3, 1));
    send_item(mk(CMD_DIFF, 2024, 3, 1, 0, 2024, 2, 0));
    send_item(mk(CMD_DIFF, 2024, 3, 1, 0, 10000, 1, 1));
    send_item(mk(CMD_DIFF, 1, 1, 1, 0, 0, 12, 31));
    settle();
  endtask

  // receiver holds off while items keep coming, so the input must stall
  task automatic test_full_stall();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_len  = 300;
    repeat (12) send_item(random_item());
    settle();
  endtask

  task automatic test_random_traffic(input int count, input bit idle);
    send_idle = idle;
    recv_idle = idle;
    repeat (count) send_item(random_item());
    settle();
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_ADD;
    in_ch.year        <= '0;
    in_ch.month       <= '0;
    in_ch.day         <= '0;
    in_ch.offset      <= '0;
    in_ch.other_year  <= '0;
    in_ch.other_month <= '0;
    in_ch.other_day   <= '0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_len  = 0;
    errors    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_full_stall();
    test_random_traffic(400, 1'b1);
    test_random_traffic(250, 1'b0);
    test_random_traffic(480, 1'b1);
    settle();
    $display("covered %0d date shifts and %0d date differences under random stalls",
             n_add, n_diff);
    $display("results seen: %0d ok, %0d invalid date, %0d out of range",
             n_ok, n_bad, n_range);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", pending_answers.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
